### design/assert_macros.svh
// assertion macros used by the deframer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must never be seen at a clock edge
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### design/ldf_pkg.sv
// shared types and constants of the length-prefixed frame deframer
package ldf_pkg;

    // header layout
    localparam int unsigned HDR_LEN     = 16;
    localparam int unsigned HDR_SHIFT_W = 8 * (HDR_LEN - 1);

    // result event codes
    localparam logic [1:0] EV_HDR  = 2'd0;
    localparam logic [1:0] EV_BODY = 2'd1;
    localparam logic [1:0] EV_ERR  = 2'd2;

    // input commands
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // configuration port
    localparam int unsigned PADDR_W      = 3;
    localparam logic        REG_MAX_BODY = 1'b0;
    localparam logic [31:0] MAX_BODY_RST = 32'd16777216;

    // result queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [31:0] frame_type;
        logic [31:0] frame_body_len;
        logic [31:0] reserved_word;
        logic [7:0]  body_byte;
        logic        frame_last;
    } out_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [FIFO_CW-1:0] count;
    } fifo_stat_t;

endpackage

### design/ldf_front.sv
// front end: accepts stream bytes, collects and checks headers, tracks body
module ldf_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  ldf_pkg::in_t  in_data,
    input  logic [31:0]   max_body_len,
    input  logic          q_full,
    output logic          push,
    output ldf_pkg::out_t push_data
);
    import ldf_pkg::*;

    logic                   in_body_reg, in_body_next;
    logic [3:0]             hdr_pos_reg, hdr_pos_next;
    logic [HDR_SHIFT_W-1:0] hdr_shift_reg, hdr_shift_next;
    logic [31:0]            body_rem_reg, body_rem_next;

    logic        accept;
    logic [31:0] total_len;
    logic [31:0] body_len;
    logic [31:0] msg_type;
    logic [31:0] resv_word;
    logic        hdr_ok;

    // stall only when the queue has no room
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // header words from the shift register and the closing byte
    assign total_len = hdr_shift_reg[HDR_SHIFT_W-1 -: 32];
    assign body_len  = hdr_shift_reg[HDR_SHIFT_W-33 -: 32];
    assign msg_type  = hdr_shift_reg[HDR_SHIFT_W-65 -: 32];
    assign resv_word = {hdr_shift_reg[23:0], in_data.data_byte};

    // header check
    assign hdr_ok = (total_len >= 32'(HDR_LEN))
                 && (body_len == total_len - 32'(HDR_LEN))
                 && (body_len <= max_body_len);

    // next state and queue write
    always_comb
    begin
        in_body_next   = in_body_reg;
        hdr_pos_next   = hdr_pos_reg;
        hdr_shift_next = hdr_shift_reg;
        body_rem_next  = body_rem_reg;
        push           = 1'b0;
        push_data      = '0;
        if (accept)
        begin
            priority if (in_data.cmd == CMD_FLUSH)
            begin
                in_body_next   = 1'b0;
                hdr_pos_next   = '0;
                hdr_shift_next = '0;
                body_rem_next  = '0;
            end
            else if (in_body_reg)
            begin
                push                = 1'b1;
                push_data.event_res = EV_BODY;
                push_data.body_byte = in_data.data_byte;
                body_rem_next       = body_rem_reg - 32'd1;
                if (body_rem_reg == 32'd1)
                begin
                    push_data.frame_last = 1'b1;
                    in_body_next         = 1'b0;
                    hdr_pos_next         = '0;
                    hdr_shift_next       = '0;
                    body_rem_next        = '0;
                end
            end
            else if (hdr_pos_reg != 4'(HDR_LEN - 1))
            begin
                hdr_shift_next = {hdr_shift_reg[HDR_SHIFT_W-9:0], in_data.data_byte};
                hdr_pos_next   = hdr_pos_reg + 4'd1;
            end
            else
            begin
                push           = 1'b1;
                hdr_pos_next   = '0;
                hdr_shift_next = '0;
                in_body_next   = 1'b0;
                body_rem_next  = '0;
                if (!hdr_ok)
                begin
                    push_data.event_res = EV_ERR;
                end
                else
                begin
                    push_data.event_res      = EV_HDR;
                    push_data.frame_type     = msg_type;
                    push_data.frame_body_len = body_len;
                    push_data.reserved_word  = resv_word;
                    if (body_len == 32'd0)
                    begin
                        push_data.frame_last = 1'b1;
                    end
                    else
                    begin
                        in_body_next  = 1'b1;
                        body_rem_next = body_len;
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg   <= 1'b0;
            hdr_pos_reg   <= '0;
            hdr_shift_reg <= '0;
            body_rem_reg  <= '0;
        end
        else
        begin
            in_body_reg   <= in_body_next;
            hdr_pos_reg   <= hdr_pos_next;
            hdr_shift_reg <= hdr_shift_next;
            body_rem_reg  <= body_rem_next;
        end
    end

endmodule

### design/ldf_fifo.sv
// short result queue between front and back
module ldf_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ldf_pkg::out_t      push_data,
    input  logic               pop,
    output ldf_pkg::out_t      pop_data,
    output ldf_pkg::fifo_stat_t stat
);
    import ldf_pkg::*;

    out_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

    assign do_push  = push && !stat.full;
    assign do_pop   = pop && !stat.empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + FIFO_AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + FIFO_AW'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + FIFO_CW'(1);
            2'b01:   count_next = count_reg - FIFO_CW'(1);
            default: count_next = count_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/ldf_back.sv
// back end: moves queued results into the output register
module ldf_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  ldf_pkg::out_t q_data,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output ldf_pkg::out_t out_data
);
    import ldf_pkg::*;

    logic out_valid_reg, out_valid_next;
    out_t out_data_reg;

    // refill when the register is empty or its transfer completes
    assign pop = !q_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= q_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### design/length_prefixed_frame_deframer.sv
// top level of the length-prefixed frame deframer
// a result is written into the result queue at the edge that takes its byte, then moves on into the output register
// throughput: one byte per cycle; input stalls only when the four-entry result queue is full
// header check runs in the cycle that takes the sixteenth header byte
// reset: rst_n clears frame state, queue and output valid; max_body_length returns to 16777216
`include "assert_macros.svh"

module length_prefixed_frame_deframer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  ldf_pkg::in_t           in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output ldf_pkg::out_t          out_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ldf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import ldf_pkg::*;

    logic       max_body_sel;
    logic [31:0] max_body_len_reg;
    logic       cfg_wr;
    logic       push;
    logic       pop;
    out_t       push_data;
    out_t       q_data;
    fifo_stat_t q_stat;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign max_body_sel = (paddr[2] == REG_MAX_BODY);
    assign prdata = max_body_sel ? max_body_len_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_len_reg <= MAX_BODY_RST;
        end
        else if (cfg_wr && max_body_sel)
        begin
            max_body_len_reg <= pwdata;
        end
    end

    ldf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .max_body_len (max_body_len_reg),
        .q_full       (q_stat.full),
        .push         (push),
        .push_data    (push_data)
    );

    ldf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (q_data),
        .stat      (q_stat)
    );

    ldf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_stat.empty),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // checks
    `ASSERT_NEVER(a_push_full, clk, rst_n, push && q_stat.full, "result pushed into a full queue")
    `ASSERT_NEVER(a_count_range, clk, rst_n, q_stat.count > FIFO_CW'(FIFO_DEPTH), "queue count overflow")
    `ASSERT_IMPLIES(a_err_zero, clk, rst_n, out_valid && out_data.event_res == EV_ERR, out_data.frame_type == 32'd0 && out_data.frame_body_len == 32'd0 && out_data.reserved_word == 32'd0 && out_data.body_byte == 8'd0 && !out_data.frame_last, "error result carries data")
    `ASSERT_IMPLIES(a_hdr_last, clk, rst_n, out_valid && out_data.event_res == EV_HDR, out_data.frame_last == (out_data.frame_body_len == 32'd0), "header frame_last does not match empty body")

endmodule

### test/deframe_checker.sv
// checker for the frame deframer: predicts results from accepted bytes and compares them
module deframe_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  ldf_pkg::in_t                in_data,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  ldf_pkg::out_t               out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ldf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    output int                          mismatches,
    output int                          results_due
);
    import ldf_pkg::*;

    // shadow of the deframer state and its register
    bit                   in_body;
    bit [3:0]             hdr_pos;
    bit [HDR_SHIFT_W-1:0] hdr_shift;
    bit [31:0]            body_left;
    bit [31:0]            body_limit;

    // results still to come, oldest first
    out_t frame_results_due[$];

    initial
    begin
        mismatches  = 0;
        results_due = 0;
        body_limit  = MAX_BODY_RST;
    end

    task automatic clear_frame();
        in_body   = 1'b0;
        hdr_pos   = '0;
        hdr_shift = '0;
        body_left = '0;
    endtask

    // work out what one accepted byte or flush produces
    task automatic track_stream_byte(input in_t item);
        out_t        res;
        logic [31:0] total;
        logic [31:0] blen;
        res = '0;
        if (item.cmd == CMD_FLUSH)
        begin
            clear_frame();
            return;
        end
        if (in_body)
        begin
            body_left     = body_left - 32'd1;
            res.event_res = EV_BODY;
            res.body_byte = item.data_byte;
            if (body_left == '0)
            begin
                res.frame_last = 1'b1;
                clear_frame();
            end
            frame_results_due = {frame_results_due, res};
        end
        else if (hdr_pos < HDR_LEN - 1)
        begin
            hdr_shift = {hdr_shift[HDR_SHIFT_W-9:0], item.data_byte};
            hdr_pos   = hdr_pos + 4'd1;
        end
        else
        begin
            // sixteenth header byte: check the header
            total = hdr_shift[HDR_SHIFT_W-1 -: 32];
            blen  = hdr_shift[HDR_SHIFT_W-33 -: 32];
            res.frame_type    = hdr_shift[HDR_SHIFT_W-65 -: 32];
            res.reserved_word = {hdr_shift[23:0], item.data_byte};
            clear_frame();
            if (total < HDR_LEN || blen != 32'(total - HDR_LEN) || blen > body_limit)
            begin
                res = '0;
                res.event_res = EV_ERR;
            end
            else
            begin
                res.event_res      = EV_HDR;
                res.frame_body_len = blen;
                if (blen == '0)
                    res.frame_last = 1'b1;
                else
                begin
                    in_body   = 1'b1;
                    body_left = blen;
                end
            end
            frame_results_due = {frame_results_due, res};
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s expected %h got %h", name, want, got);
            mismatches++;
        end
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            clear_frame();
            body_limit = MAX_BODY_RST;
            frame_results_due.delete();
            results_due = 0;
        end
        else
        begin
            // result transfer
            if (out_valid && !out_stall)
            begin
                if (frame_results_due.size() == 0)
                begin
                    $error("unexpected result event_res %h", out_data.event_res);
                    mismatches++;
                end
                else
                begin
                    want = frame_results_due.pop_front();
                    check_field("event_res", 32'(want.event_res), 32'(out_data.event_res));
                    check_field("frame_type", want.frame_type, out_data.frame_type);
                    check_field("frame_body_len", want.frame_body_len,
                                out_data.frame_body_len);
                    check_field("reserved_word", want.reserved_word, out_data.reserved_word);
                    check_field("body_byte", 32'(want.body_byte), 32'(out_data.body_byte));
                    check_field("frame_last", 32'(want.frame_last), 32'(out_data.frame_last));
                end
            end
            // register write
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_MAX_BODY)
                body_limit = pwdata;
            // byte transfer
            if (in_valid && !in_stall)
                track_stream_byte(in_data);
            results_due = frame_results_due.size();
        end
    end

endmodule

### test/tb_top.sv
// testbench top for the frame deframer: stimulus, register writes and verdict
module tb_top;
    import ldf_pkg::*;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int PHASE_ITEMS   = 265;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 6;
    localparam logic [31:0] BODY_LIMIT_TOP = 32'hFFFF_FFEF;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    in_t                in_data;
    logic               out_valid;
    logic               out_stall;
    out_t               out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int mismatches;
    int results_due;
    int cycle_count = 0;
    int items_sent  = 0;
    bit idle_on     = 1'b0;
    bit hold_req    = 1'b0;
    logic [31:0] body_limit;

    length_prefixed_frame_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    deframe_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver side: random stall bursts, quiet stretches and one long hold
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 30) == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(20, 60)) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // one transfer on the byte channel, then maybe a gap
    task automatic send_item(input logic cmd, input logic [7:0] data_byte);
        in_data  <= '{cmd: cmd, data_byte: data_byte};
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    task automatic send_flush();
        send_item(CMD_FLUSH, 8'($urandom));
    endtask

    // register write: setup then access
    task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop offering bytes and wait until every result has come out
    task automatic drain();
        in_valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '1;
        if (r == 1)
            return '0;
        return $urandom;
    endfunction

    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'hFF;
        if (r == 1)
            return 8'h00;
        return 8'($urandom);
    endfunction

    // header bytes, most significant first; cut_at below 16 ends early with a flush
    task automatic send_header(input logic [31:0] total, input logic [31:0] blen,
                               input logic [31:0] mtype, input logic [31:0] resv,
                               input int cut_at);
        logic [127:0] hdr;
        hdr = {total, blen, mtype, resv};
        for (int i = 0; i < HDR_LEN; i++)
        begin
            if (i == cut_at)
            begin
                send_flush();
                return;
            end
            send_item(CMD_DATA, hdr[127 - 8*i -: 8]);
        end
    endtask

    // one random frame: valid, broken or plain noise
    task automatic send_random_frame();
        int unsigned kind;
        int          cut_at;
        int unsigned n_body;
        logic [31:0] total;
        logic [31:0] blen;
        logic [31:0] cap;
        bit          huge;
        kind   = $urandom_range(0, 99);
        cut_at = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 15) : HDR_LEN;
        huge   = 1'b0;
        if (kind < 8)
        begin
            // noise, then a flush to find the frame start again
            repeat ($urandom_range(1, 20)) send_item(CMD_DATA, 8'($urandom));
            send_flush();
            return;
        end
        else if (kind < 18)
        begin
            // total length shorter than the header
            total = $urandom_range(0, 15);
            blen  = ($urandom_range(0, 1) == 0) ? 32'(total - HDR_LEN) : pick_word();
        end
        else if (kind < 26 || (kind < 34 && body_limit == BODY_LIMIT_TOP))
        begin
            // body length disagrees with total length
            total = ($urandom_range(0, 1) == 0) ? $urandom_range(16, 60) : ($urandom | 32'h10);
            blen  = 32'(total - HDR_LEN) + $urandom_range(1, 5);
        end
        else if (kind < 34)
        begin
            // body longer than the configured limit
            blen  = (body_limit > BODY_LIMIT_TOP - 4) ? body_limit + 32'd1
                                                      : body_limit + 32'd1 + $urandom_range(0, 3);
            total = blen + HDR_LEN;
        end
        else
        begin
            // well-formed frame
            if (body_limit >= 32'hFFFF_0000 && $urandom_range(0, 5) == 0)
            begin
                blen = body_limit - $urandom_range(0, 2);
                huge = 1'b1;
            end
            else
            begin
                cap = (body_limit < 24) ? body_limit : 32'd24;
                if ($urandom_range(0, 9) == 0)
                    cap = (body_limit < 300) ? body_limit : 32'd300;
                blen = ($urandom_range(0, 5) == 0) ? cap : $urandom_range(0, cap);
            end
            total = blen + HDR_LEN;
        end
        send_header(total, blen, pick_word(), pick_word(), cut_at);
        if (cut_at < HDR_LEN || kind < 34 || blen == 0)
            return;
        // body, sometimes cut short by a flush
        n_body = blen;
        if (huge)
            n_body = $urandom_range(1, 6);
        else if (blen > 1 && $urandom_range(0, 14) == 0)
            n_body = $urandom_range(1, blen - 1);
        repeat (n_body) send_item(CMD_DATA, pick_byte());
        if (n_body != blen)
            send_flush();
    endtask

    // random frames until the phase has its share of bytes
    task automatic run_phase(input bit with_idle);
        int start;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
        begin
            idle_on = with_idle && ($urandom_range(0, 3) != 0);
            send_random_frame();
        end
        idle_on = 1'b0;
        drain();
    endtask

    // main sequence
    initial
    begin
        logic [31:0] phase_limits [5];
        phase_limits = '{32'd0, 32'd5, BODY_LIMIT_TOP, 32'd300, MAX_BODY_RST};

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        body_limit = MAX_BODY_RST;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: flush inside a header, then a frame with extreme header words
        send_item(CMD_DATA, 8'hAB);
        send_item(CMD_DATA, 8'hCD);
        send_flush();
        send_header(32'd18, 32'd2, 32'hFFFF_FFFF, 32'h0000_0000, HDR_LEN);
        send_item(CMD_DATA, 8'hFF);
        send_item(CMD_DATA, 8'h00);
        drain();

        // random phases under the reset limit and then under each written limit
        run_phase(1'b1);
        for (int p = 0; p < 5; p++)
        begin
            body_limit = phase_limits[p];
            write_register({REG_MAX_BODY, 2'b00}, body_limit);
            // a write to an address with no register must change nothing
            if (p == 1)
                write_register({~REG_MAX_BODY, 2'b00}, $urandom);
            // fill the result queue with the receiver held off
            if (p == 3)
                hold_req = 1'b1;
            run_phase(p != 4);
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
